// File: hw/rtl/sha2d_pkg.sv
// ----------------------------------------------------------------------------
// sha2d_pkg
// Shared types, constants and round functions of the SHA-224/256 digest core.
// ----------------------------------------------------------------------------
package sha2d_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } state_e;

  // compression unit control from the sequencer
  typedef struct packed {
    logic start;
    logic wr_byte;
    logic [5:0] byte_pos;
    logic [7:0] byte_val;
    logic pad_clear;
    logic [4:0] pad_from;
    logic len_wr;
    logic [63:0] bit_len;
    logic zero_win;
    logic load_iv;
    logic mode;
  } cmp_ctrl_t;

  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [31:0] Iv256 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
  localparam logic [31:0] Iv224 [8] = '{
    32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
    32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4};

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// File: hw/rtl/sha2d_compress.sv
// ----------------------------------------------------------------------------
// sha2d_compress
// Schedule window, working variables and chaining value; one round per cycle.
// ----------------------------------------------------------------------------
module sha2d_compress
  import sha2d_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmp_ctrl_t   ctrl_i,
  output logic        busy_o,
  input  logic [2:0]  rd_idx_i,
  output logic [31:0] rd_word_o
);

  logic [31:0] win_q [16];
  logic [31:0] var_q [8];
  logic [31:0] chain_q [8];
  logic [5:0]  rnd_q, rnd_d;
  logic        run_q, run_d, fold_q, fold_d;

  logic [31:0] w_new, wi, t1, t2, s0, s1, ch, mj, ep0, ep1;

  // message schedule and round function
  always_comb begin
    s0 = rotr(win_q[1], 7) ^ rotr(win_q[1], 18) ^ (win_q[1] >> 3);
    s1 = rotr(win_q[14], 17) ^ rotr(win_q[14], 19) ^ (win_q[14] >> 10);
    w_new = win_q[0] + s0 + win_q[9] + s1;
    wi = (rnd_q < 6'd16) ? win_q[0] : w_new;
    ep1 = rotr(var_q[4], 6) ^ rotr(var_q[4], 11) ^ rotr(var_q[4], 25);
    ch = (var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]);
    ep0 = rotr(var_q[0], 2) ^ rotr(var_q[0], 13) ^ rotr(var_q[0], 22);
    mj = (var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]);
    t1 = var_q[7] + ep1 + ch + RoundK[rnd_q] + wi;
    t2 = ep0 + mj;
  end

  // round sequencing
  always_comb begin
    run_d = run_q;
    rnd_d = rnd_q;
    fold_d = 1'b0;
    if (ctrl_i.start) begin
      run_d = 1'b1;
      rnd_d = '0;
    end else if (run_q) begin
      rnd_d = rnd_q + 6'd1;
      if (rnd_q == 6'd63) begin
        run_d = 1'b0;
        fold_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      fold_q <= 1'b0;
      rnd_q <= '0;
    end else begin
      run_q <= run_d;
      fold_q <= fold_d;
      rnd_q <= rnd_d;
    end
  end

  assign busy_o = run_q | fold_q;

  // window: byte writes, padding, and rotation during rounds
  always_ff @(posedge clk_i) begin
    if (run_q) begin
      for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
      win_q[15] <= wi;
    end else begin
      if (ctrl_i.zero_win) begin
        for (int i = 0; i < 16; i++) win_q[i] <= '0;
      end
      if (ctrl_i.pad_clear) begin
        for (int i = 0; i < 16; i++) begin
          if (5'(i) >= ctrl_i.pad_from) win_q[i] <= '0;
        end
      end
      if (ctrl_i.wr_byte) begin
        case (ctrl_i.byte_pos[1:0])
          2'd0: win_q[ctrl_i.byte_pos[5:2]] <= {ctrl_i.byte_val, 24'h0};
          2'd1: win_q[ctrl_i.byte_pos[5:2]][23:16] <= ctrl_i.byte_val;
          2'd2: win_q[ctrl_i.byte_pos[5:2]][15:8] <= ctrl_i.byte_val;
          default: win_q[ctrl_i.byte_pos[5:2]][7:0] <= ctrl_i.byte_val;
        endcase
      end
      if (ctrl_i.len_wr) begin
        win_q[14] <= ctrl_i.bit_len[63:32];
        win_q[15] <= ctrl_i.bit_len[31:0];
      end
    end
  end

  // working variables
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      for (int i = 0; i < 8; i++) var_q[i] <= chain_q[i];
    end else if (run_q) begin
      var_q[7] <= var_q[6];
      var_q[6] <= var_q[5];
      var_q[5] <= var_q[4];
      var_q[4] <= var_q[3] + t1;
      var_q[3] <= var_q[2];
      var_q[2] <= var_q[1];
      var_q[1] <= var_q[0];
      var_q[0] <= t1 + t2;
    end
  end

  // chaining value: reset to SHA-256 IV, fold after rounds, reload on re-arm
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) chain_q[i] <= Iv256[i];
    end else if (fold_q) begin
      for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + var_q[i];
    end else if (ctrl_i.load_iv) begin
      for (int i = 0; i < 8; i++) chain_q[i] <= ctrl_i.mode ? Iv224[i] : Iv256[i];
    end
  end

  assign rd_word_o = chain_q[rd_idx_i];

endmodule

// File: hw/rtl/sha224_sha256_digest_core.sv
// ----------------------------------------------------------------------------
// sha224_sha256_digest_core
// Byte-streaming SHA-256 / SHA-224 digest engine.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry one message byte (data_byte_i) with final_byte_i on the
//   last byte, or empty_message_i to end a message without a byte. A byte
//   that does not fill a block is taken without a stall. A byte that completes
//   a 64-byte block holds the input stalled through the 64 rounds of the
//   shared round unit, the fold of the chain and the sequencer's ROUND and
//   FOLD states. A final beat runs padding: a pad step, then one or two
//   compressions, before the first digest beat. The digest is sent as 8
//   words (7 for SHA-224), most significant first, last_word_o on the last
//   one.
//   The input is stalled until the last digest beat is taken; a stall on
//   the output simply holds the current word.
//   The mode register is written on cfg_valid/cfg_ready while idle; a write
//   with no bytes pending reloads the initial value of the new mode.
//   Reset: SHA-256 mode, SHA-256 initial value, zero byte count.
// ----------------------------------------------------------------------------
module sha224_sha256_digest_core
  import sha2d_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data_i,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte_i,
  input  logic        final_byte_i,
  input  logic        empty_message_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word_o,
  output logic        last_word_o
);

  state_e      state_q, state_d;
  logic        mode_q;
  logic [60:0] count_q, count_d;
  logic [1:0]  padn_q, padn_d;   // compressions left in padding
  logic        fin_q, fin_d;     // a final beat is waiting on a block compress
  logic [2:0]  widx_q, widx_d;
  logic        busy;
  cmp_ctrl_t   ctrl;
  logic [5:0]  pos;
  logic        in_acc, out_acc;

  sha2d_compress u_cmp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .busy_o    (busy),
    .rd_idx_i  (widx_q),
    .rd_word_o (digest_word_o)
  );

  assign cfg_ready = (state_q == ST_IDLE);
  assign pos = count_q[5:0];
  assign in_stall = (state_q != ST_IDLE);
  assign in_acc = in_valid & ~in_stall;
  assign out_valid = (state_q == ST_EMIT);
  assign out_acc = out_valid & ~out_stall;
  assign last_word_o = (widx_q == (mode_q ? 3'd6 : 3'd7));

  // sequencer
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    padn_d = padn_q;
    fin_d = fin_q;
    widx_d = widx_q;
    ctrl = '0;
    ctrl.mode = mode_q;
    ctrl.byte_pos = pos;
    ctrl.bit_len = {count_q, 3'b000};
    ctrl.pad_from = {1'b0, pos[5:2]} + 5'd1;
    case (state_q)
      ST_IDLE: begin
        if (cfg_valid && count_q == '0) begin
          ctrl.load_iv = 1'b1;
          ctrl.mode = cfg_data_i;
        end
        if (in_acc) begin
          if (empty_message_i) begin
            state_d = ST_PAD;
          end else begin
            ctrl.wr_byte = 1'b1;
            ctrl.byte_val = data_byte_i;
            count_d = count_q + 61'd1;
            if (pos == 6'd63) begin
              ctrl.start = 1'b1;
              fin_d = final_byte_i;
              state_d = ST_ROUND;
            end else if (final_byte_i) begin
              state_d = ST_PAD;
            end
          end
        end
      end
      ST_PAD: begin
        // write the pad byte, zero the tail, then the length if it fits
        ctrl.wr_byte = 1'b1;
        ctrl.byte_val = PadByte;
        ctrl.pad_clear = 1'b1;
        ctrl.start = 1'b1;
        if (pos >= 6'd56) begin
          padn_d = 2'd2;
        end else begin
          ctrl.len_wr = 1'b1;
          padn_d = 2'd1;
        end
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        if (!busy) state_d = ST_FOLD;
      end
      ST_FOLD: begin
        // chain is folded; decide what follows
        if (fin_q) begin
          fin_d = 1'b0;
          state_d = ST_PAD;
        end else if (padn_q == 2'd2) begin
          ctrl.zero_win = 1'b1;
          ctrl.len_wr = 1'b1;
          ctrl.start = 1'b1;
          padn_d = 2'd1;
          state_d = ST_ROUND;
        end else if (padn_q == 2'd1) begin
          padn_d = 2'd0;
          widx_d = '0;
          state_d = ST_EMIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          widx_d = widx_q + 3'd1;
          if (last_word_o) begin
            widx_d = '0;
            count_d = '0;
            ctrl.load_iv = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mode_q <= 1'b0;
      count_q <= '0;
      padn_q <= '0;
      fin_q <= 1'b0;
      widx_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      padn_q <= padn_d;
      fin_q <= fin_d;
      widx_q <= widx_d;
      if (cfg_valid && cfg_ready) mode_q <= cfg_data_i;
    end
  end

endmodule

// File: tb/sv/sha224_sha256_digest_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha224_sha256_digest_core_test
// Streams messages of random and boundary lengths through the digest core in
// both modes, predicts every digest word with a local SHA-224/256 model and
// compares each output beat in order under random input gaps and output
// stalls.
// ----------------------------------------------------------------------------
module sha224_sha256_digest_core_test;
  import sha2d_pkg::*;

  localparam int unsigned WatchdogLimit = 20000;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } digest_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data_i = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte_i = '0;
  logic        final_byte_i = 1'b0;
  logic        empty_message_i = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] digest_word_o;
  logic        last_word_o;

  sha224_sha256_digest_core dut (.*);

  // predictor state
  logic        pred_mode;
  logic [31:0] pred_chain [8];
  logic [31:0] pred_block [16];
  logic [60:0] pred_count;
  digest_beat_t digest_queue [$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  bit          stall_enable = 1'b1;

  initial forever #10 clk_i = ~clk_i;

  function automatic logic [31:0] ror32(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] iv_word(logic mode, int unsigned i);
    return mode ? Iv224[i] : Iv256[i];
  endfunction

  task automatic load_chain_iv();
    for (int i = 0; i < 8; i++) pred_chain[i] = iv_word(pred_mode, i);
  endtask

  task automatic compress_block();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] wi, t1, t2, x15, x2;
    for (int i = 0; i < 16; i++) w[i] = pred_block[i];
    for (int i = 0; i < 8; i++) v[i] = pred_chain[i];
    for (int i = 0; i < 64; i++) begin
      if (i < 16) begin
        wi = w[i];
      end else begin
        x15 = w[(i + 1) & 15];
        x2 = w[(i + 14) & 15];
        wi = w[i & 15] + (ror32(x15, 7) ^ ror32(x15, 18) ^ (x15 >> 3))
           + w[(i + 9) & 15] + (ror32(x2, 17) ^ ror32(x2, 19) ^ (x2 >> 10));
        w[i & 15] = wi;
      end
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[i] + wi;
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) pred_chain[i] += v[i];
  endtask

  task automatic place_byte(int unsigned pos, logic [7:0] b);
    int unsigned sh;
    sh = 24 - 8 * (pos & 3);
    if ((pos & 3) == 0) pred_block[pos >> 2] = '0;
    pred_block[pos >> 2] |= 32'(b) << sh;
  endtask

  // padding, length, final compression(s) and digest words
  task automatic close_message();
    int unsigned pos;
    logic [63:0] bits;
    int unsigned nwords;
    digest_beat_t beat;
    pos = 32'(pred_count[5:0]);
    bits = {pred_count, 3'b000};
    place_byte(pos, PadByte);
    for (int i = (pos >> 2) + 1; i < 16; i++) pred_block[i] = '0;
    if (pos >= 56) begin
      compress_block();
      for (int i = 0; i < 16; i++) pred_block[i] = '0;
    end
    pred_block[14] = bits[63:32];
    pred_block[15] = bits[31:0];
    compress_block();
    nwords = pred_mode ? 7 : 8;
    for (int i = 0; i < nwords; i++) begin
      beat.word = pred_chain[i];
      beat.last = (i + 1 == nwords);
      digest_queue = {digest_queue, beat};
    end
    pred_count = '0;
    load_chain_iv();
  endtask

  task automatic predict_beat(logic [7:0] b, logic fin, logic empty);
    int unsigned pos;
    if (empty) begin
      close_message();
    end else begin
      pos = 32'(pred_count[5:0]);
      place_byte(pos, b);
      pred_count = pred_count + 1'b1;
      if (pos == 63) compress_block();
      if (fin) close_message();
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic int unsigned gap_length();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
  endfunction

  // one input beat, with a random gap ahead of it
  task automatic send_byte(logic [7:0] b, logic fin, logic empty, bit gaps = 1'b1);
    int unsigned gap;
    gap = gaps ? gap_length() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    data_byte_i <= b;
    final_byte_i <= fin;
    empty_message_i <= empty;
    do @(posedge clk_i); while (in_stall);
    predict_beat(b, fin, empty);
  endtask

  task automatic send_message(int unsigned len, bit gaps = 1'b1);
    if (len == 0) begin
      send_byte(8'($urandom), 1'($urandom), 1'b1, gaps);
    end else begin
      for (int i = 0; i < len; i++) send_byte(8'($urandom), (i == len - 1), 1'b0, gaps);
    end
  endtask

  task automatic drain_digests();
    in_valid <= 1'b0;
    while (digest_queue.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_mode(logic mode);
    cfg_valid <= 1'b1;
    cfg_data_i <= mode;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pred_mode = mode;
    if (pred_count == 0) load_chain_iv();
  endtask

  // output stall pattern
  always @(posedge clk_i) begin
    if (!stall_enable) out_stall <= 1'b0;
    else if ($urandom_range(0, 19) == 0) out_stall <= 1'b1;
    else if (out_stall && $urandom_range(0, 3) != 0) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(0, 4) == 0);
  end

  // digest beat checker and watchdog
  always @(posedge clk_i) begin
    digest_beat_t want;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (digest_queue.size() == 0) begin
          report_mismatch("unexpected beat", digest_word_o, '0);
        end else begin
          want = digest_queue.pop_front();
          if (digest_word_o !== want.word) report_mismatch("digest_word", digest_word_o, want.word);
          if (last_word_o !== want.last) report_mismatch("last_word", 32'(last_word_o), 32'(want.last));
        end
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic test_known_lengths();
    // empty, one byte, the padding split points and one full block
    int unsigned lens [6] = '{0, 1, 55, 56, 63, 64};
    foreach (lens[i]) send_message(lens[i], 1'b0);
    send_byte(8'hff, 1'b1, 1'b1);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hff, 1'b0, 1'b0);
    send_byte(8'h5a, 1'b0, 1'b1);
    drain_digests();
  endtask

  task automatic test_sha224_mode();
    write_mode(1'b1);
    send_message(0);
    send_message(3);
    send_message(20);
    drain_digests();
  endtask

  task automatic test_mode_switch_mid_message();
    send_byte(8'h12, 1'b0, 1'b0);
    send_byte(8'h34, 1'b0, 1'b0);
    drain_digests();
    write_mode(1'b0);
    send_byte(8'h56, 1'b1, 1'b0);
    drain_digests();
  endtask

  task automatic test_random_messages();
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < 90) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 70) : $urandom_range(0, 12);
      send_message(len);
      sent += (len == 0) ? 1 : len;
      if ($urandom_range(0, 9) == 0) begin
        drain_digests();
        write_mode(1'($urandom));
      end
      if ($urandom_range(0, 15) == 0) stall_enable = ~stall_enable;
    end
    stall_enable = 1'b1;
    drain_digests();
  endtask

  initial begin
    pred_mode = 1'b0;
    pred_count = '0;
    load_chain_iv();
    for (int i = 0; i < 16; i++) pred_block[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_known_lengths();
    test_sha224_mode();
    test_mode_switch_mid_message();
    test_random_messages();
    if (mismatches == 0 && digest_queue.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
